// ----- hw/rtl/esc_pkg.sv -----
// Package for the epoch seconds to calendar converter.
// Holds the calendar constants and the month length table. No dependencies.

package esc_pkg;

   // Width of the shared compare-subtract unit operands.
   localparam int unsigned AluWidth = 12;

   // Divisors used by the shift-subtract division passes.
   localparam logic [AluWidth-1:0] SecPerMin    = 12'd60;
   localparam logic [AluWidth-1:0] MinPerHour   = 12'd60;
   localparam logic [AluWidth-1:0] HourPerDay   = 12'd24;
   localparam logic [AluWidth-1:0] DaysPerWeek  = 12'd7;
   localparam logic [AluWidth-1:0] DaysPerCycle = 12'd1461;

   // Year thresholds inside a four-year cycle; the third year is the leap year.
   localparam logic [AluWidth-1:0] DaysToFourth = 12'd1096;
   localparam logic [AluWidth-1:0] DaysToThird  = 12'd730;
   localparam logic [AluWidth-1:0] DaysToSecond = 12'd365;

   // Day of year of February 29 in a leap year.
   localparam logic [10:0] Feb29Yday = 11'd59;

   // 1970-01-01 was a Thursday.
   localparam logic [15:0] EpochWeekday = 16'd4;

   // Calendar year of the epoch, counted from 1900.
   localparam logic [7:0] BaseYear = 8'd70;

   // Last month index reached by the month walk.
   localparam logic [3:0] LastMonth = 4'd11;

   // Length of each month in a common year; indexes past December read 31.
   function automatic logic [4:0] month_length(input logic [3:0] mon);
      logic [4:0] len;
      case (mon)
         4'd1:    len = 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- hw/rtl/epoch_seconds_to_calendar_core.sv -----
// Epoch seconds to calendar converter, top level.
// Depends on esc_pkg for the calendar constants and month length table.

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, weekday, year since 1900, day of year, month and day
// of month. The century leap rule is not applied, so 2100 counts as a leap
// year. A single 12-bit compare-subtract unit produces one quotient bit a
// cycle over five divisions. It then places the year and applies the leap
// day shift where needed. The month walk passes one month at a time and then
// settles the day of month, and February 29 skips the walk. The result
// register is loaded last, and that load waits while the previous result is
// still held there. The block takes no new word while a conversion runs,
// but it does take one while a finished result still waits on the response
// side.

module epoch_seconds_to_calendar_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [2:0]  rsp_weekday,
   output logic [7:0]  rsp_year_since_1900,
   output logic [8:0]  rsp_day_of_year,
   output logic [3:0]  rsp_month_index,
   output logic [4:0]  rsp_day_of_month
);
   import esc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_YEAR,
      ST_FIX,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_SEC,
      OP_MIN,
      OP_HOUR,
      OP_WDAY,
      OP_CYCLE
   } op_type;

   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic [31:0] dq_ff, dq_in;
   logic [10:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] days_ff, days_in;
   logic [1:0]  ystep_ff, ystep_in;
   logic [3:0]  mon_ff, mon_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [2:0]  wday_ff, wday_in;
   logic [7:0]  year_ff, year_in;
   logic [8:0]  yday_ff, yday_in;
   logic [4:0]  mday_ff, mday_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_second_ff, rsp_second_in;
   logic [5:0]  rsp_minute_ff, rsp_minute_in;
   logic [4:0]  rsp_hour_ff, rsp_hour_in;
   logic [2:0]  rsp_weekday_ff, rsp_weekday_in;
   logic [7:0]  rsp_year_ff, rsp_year_in;
   logic [8:0]  rsp_yday_ff, rsp_yday_in;
   logic [3:0]  rsp_mon_ff, rsp_mon_in;
   logic [4:0]  rsp_mday_ff, rsp_mday_in;

   // Shared compare-subtract unit.
   logic [AluWidth-1:0] alu_a, alu_b, trial, divisor;
   logic [AluWidth:0]   alu_diff;
   logic                alu_ge;

   // Division pass results and year step helpers.
   logic [10:0] rem_nx;
   logic [31:0] quo_nx;
   logic [10:0] t_nx;
   logic        leap_nx;
   logic        year_done;

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_second          = rsp_second_ff;
   assign rsp_minute          = rsp_minute_ff;
   assign rsp_hour            = rsp_hour_ff;
   assign rsp_weekday         = rsp_weekday_ff;
   assign rsp_year_since_1900 = rsp_year_ff;
   assign rsp_day_of_year     = rsp_yday_ff;
   assign rsp_month_index     = rsp_mon_ff;
   assign rsp_day_of_month    = rsp_mday_ff;

   // Divisor for the current division pass.
   always_comb begin
      unique case (op_ff)
         OP_SEC:   divisor = SecPerMin;
         OP_MIN:   divisor = MinPerHour;
         OP_HOUR:  divisor = HourPerDay;
         OP_WDAY:  divisor = DaysPerWeek;
         OP_CYCLE: divisor = DaysPerCycle;
         default:  divisor = DaysPerCycle;
      endcase
   end

   // Operand selection for the shared unit.
   assign trial = {rem_ff, dq_ff[31]};

   always_comb begin
      alu_a = {1'b0, rem_ff};
      alu_b = '0;
      unique case (state_ff)
         ST_DIV: begin
            alu_a = trial;
            alu_b = divisor;
         end
         ST_YEAR: begin
            unique case (ystep_ff)
               2'd0:    alu_b = DaysToFourth;
               2'd1:    alu_b = DaysToThird;
               default: alu_b = DaysToSecond;
            endcase
         end
         ST_FIX:   alu_b = {{(AluWidth-1){1'b0}}, 1'b1};
         ST_MONTH: alu_b = {7'd0, month_length(mon_ff)};
         default:  alu_b = '0;
      endcase
   end

   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = ~alu_diff[AluWidth];

   // One division step: restoring shift-subtract.
   assign rem_nx = alu_ge ? alu_diff[10:0] : trial[10:0];
   assign quo_nx = {dq_ff[30:0], alu_ge};

   // Year placement: day offset and leap flag once the year is settled.
   assign t_nx      = alu_ge ? alu_diff[10:0] : rem_ff;
   assign leap_nx   = alu_ge && (ystep_ff == 2'd1);
   assign year_done = alu_ge || (ystep_ff == 2'd2);

   // Sequencer and datapath next values.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      dq_in          = dq_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      days_in        = days_ff;
      ystep_in       = ystep_ff;
      mon_in         = mon_ff;
      sec_in         = sec_ff;
      min_in         = min_ff;
      hour_in        = hour_ff;
      wday_in        = wday_ff;
      year_in        = year_ff;
      yday_in        = yday_ff;
      mday_in        = mday_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_second_in  = rsp_second_ff;
      rsp_minute_in  = rsp_minute_ff;
      rsp_hour_in    = rsp_hour_ff;
      rsp_weekday_in = rsp_weekday_ff;
      rsp_year_in    = rsp_year_ff;
      rsp_yday_in    = rsp_yday_ff;
      rsp_mon_in     = rsp_mon_ff;
      rsp_mday_in    = rsp_mday_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dq_in    = req_epoch_seconds;
               rem_in   = '0;
               cnt_in   = 5'd31;
               op_in    = OP_SEC;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            rem_in = rem_nx;
            dq_in  = quo_nx;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               // Pass complete: keep the remainder, align the quotient for the next pass.
               rem_in = '0;
               unique case (op_ff)
                  OP_SEC: begin
                     sec_in = rem_nx[5:0];
                     dq_in  = {quo_nx[26:0], 5'd0};
                     cnt_in = 5'd26;
                     op_in  = OP_MIN;
                  end
                  OP_MIN: begin
                     min_in = rem_nx[5:0];
                     dq_in  = {quo_nx[20:0], 11'd0};
                     cnt_in = 5'd20;
                     op_in  = OP_HOUR;
                  end
                  OP_HOUR: begin
                     hour_in = rem_nx[4:0];
                     days_in = quo_nx[15:0];
                     dq_in   = {quo_nx[15:0] + EpochWeekday, 16'd0};
                     cnt_in  = 5'd15;
                     op_in   = OP_WDAY;
                  end
                  OP_WDAY: begin
                     wday_in = rem_nx[2:0];
                     dq_in   = {days_ff, 16'd0};
                     cnt_in  = 5'd15;
                     op_in   = OP_CYCLE;
                  end
                  default: begin
                     year_in  = BaseYear + {quo_nx[5:0], 2'b00};
                     rem_in   = rem_nx;
                     ystep_in = 2'd0;
                     state_in = ST_YEAR;
                  end
               endcase
            end
         end

         ST_YEAR: begin
            if (year_done) begin
               rem_in  = t_nx;
               yday_in = t_nx[8:0];
               mon_in  = '0;
               if (alu_ge) begin
                  year_in = year_ff + {6'd0, 2'd3 - ystep_ff};
               end
               // February 29 is settled here; later leap days shift back a day.
               if (leap_nx && (t_nx == Feb29Yday)) begin
                  mon_in   = 4'd1;
                  mday_in  = 5'd29;
                  state_in = ST_DONE;
               end else if (leap_nx && (t_nx > Feb29Yday)) begin
                  state_in = ST_FIX;
               end else begin
                  state_in = ST_MONTH;
               end
            end else begin
               ystep_in = ystep_ff + 2'd1;
            end
         end

         ST_FIX: begin
            rem_in   = alu_diff[10:0];
            state_in = ST_MONTH;
         end

         ST_MONTH: begin
            // Walk the month table one month a cycle.
            if ((mon_ff < LastMonth) && alu_ge) begin
               rem_in = alu_diff[10:0];
               mon_in = mon_ff + 4'd1;
            end else begin
               mday_in  = rem_ff[4:0] + 5'd1;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // Load the result register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_second_in  = sec_ff;
               rsp_minute_in  = min_ff;
               rsp_hour_in    = hour_ff;
               rsp_weekday_in = wday_ff;
               rsp_year_in    = year_ff;
               rsp_yday_in    = yday_ff;
               rsp_mon_in     = mon_ff;
               rsp_mday_in    = mday_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State, datapath and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      dq_ff          <= dq_in;
      rem_ff         <= rem_in;
      cnt_ff         <= cnt_in;
      days_ff        <= days_in;
      ystep_ff       <= ystep_in;
      mon_ff         <= mon_in;
      sec_ff         <= sec_in;
      min_ff         <= min_in;
      hour_ff        <= hour_in;
      wday_ff        <= wday_in;
      year_ff        <= year_in;
      yday_ff        <= yday_in;
      mday_ff        <= mday_in;
      rsp_second_ff  <= rsp_second_in;
      rsp_minute_ff  <= rsp_minute_in;
      rsp_hour_ff    <= rsp_hour_in;
      rsp_weekday_ff <= rsp_weekday_in;
      rsp_year_ff    <= rsp_year_in;
      rsp_yday_ff    <= rsp_yday_in;
      rsp_mon_ff     <= rsp_mon_in;
      rsp_mday_ff    <= rsp_mday_in;
   end

endmodule
